@@ hdl/lcd4_pkg.sv @@
package lcd4_pkg;

    // command codes carried in s_tuser
    typedef enum logic [2:0] {
        OP_DATA       = 3'd0,
        OP_GOTO       = 3'd1,
        OP_LINE_START = 3'd2,
        OP_CLEAR      = 3'd3,
        OP_INIT       = 3'd4,
        OP_DISPLAY    = 3'd5,
        OP_BACKLIGHT  = 3'd6,
        OP_UNUSED     = 3'd7
    } op_t;

    // switch mode codes
    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_ON     = 2'd1;
    localparam logic [1:0] MODE_TOGGLE = 2'd2;

    // ddram line base addresses
    localparam logic [7:0] LINE1_BASE = 8'h80;
    localparam logic [7:0] LINE2_BASE = 8'hC0;
    localparam logic [7:0] LINE3_BASE = 8'h94;
    localparam logic [7:0] LINE4_BASE = 8'hD4;

    // display on/off nibbles
    localparam logic [3:0] DISP_ON_NIB  = 4'hA;
    localparam logic [3:0] DISP_OFF_NIB = 4'h8;

    // timing in microseconds
    localparam logic [15:0] PRE_DATA_US   = 16'd1;
    localparam logic [15:0] PRE_INIT_US   = 16'd40000;
    localparam logic [10:0] PULSE_STD_US  = 11'd40;
    localparam logic [10:0] PULSE_LONG_US = 11'd2000;
    localparam logic [10:0] PULSE_GOTO_US = 11'd4;
    localparam logic [10:0] PULSE_HOME_US = 11'd20;
    localparam logic [10:0] POST_STD_US   = 11'd40;
    localparam logic [10:0] POST_LONG_US  = 11'd2000;

    // init sequence step markers
    localparam logic [3:0] INIT_LONG_STEP = 4'd6;
    localparam logic [3:0] INIT_LAST_STEP = 4'd8;

    typedef struct packed {
        logic [1:0] switch_mode;
        logic [7:0] column;
        logic [2:0] line;
        logic [7:0] byte_value;
        op_t        operation;
    } cmd_t;

    typedef struct packed {
        logic        last;
        logic        backlight;
        logic        strobe_res;
        logic [10:0] post_wait_us;
        logic [10:0] pulse_us;
        logic [15:0] pre_wait_us;
        logic        reg_select;
        logic [3:0]  nibble;
    } res_t;

    // nibbles of the power-on init sequence
    function automatic logic [3:0] init_nibble(input logic [3:0] step);
        logic [3:0] nib;
        unique case (step)
            4'd0:    nib = 4'h2;
            4'd1:    nib = 4'h2;
            4'd2:    nib = 4'h8;
            4'd3:    nib = 4'h0;
            4'd4:    nib = 4'hE;
            4'd5:    nib = 4'h0;
            4'd6:    nib = 4'h1;
            4'd7:    nib = 4'h0;
            4'd8:    nib = 4'h6;
            default: nib = 4'h0;
        endcase
        return nib;
    endfunction

    // ddram base of a display line, zero for lines out of range
    function automatic logic [7:0] line_base(input logic [2:0] line);
        logic [7:0] base;
        unique case (line)
            3'd1:    base = LINE1_BASE;
            3'd2:    base = LINE2_BASE;
            3'd3:    base = LINE3_BASE;
            3'd4:    base = LINE4_BASE;
            default: base = 8'h00;
        endcase
        return base;
    endfunction

endpackage

@@ hdl/lcd4_strobe_gen.sv @@
module lcd4_strobe_gen (
    input  lcd4_pkg::cmd_t     cmd,
    input  logic [3:0]         step,
    input  logic               backlight_cur,
    output lcd4_pkg::res_t     res
);
    import lcd4_pkg::*;

    logic [7:0] addr;
    logic [7:0] goto_addr;
    logic       hi_step;
    logic       bl_next;

    assign goto_addr = line_base(cmd.line) + cmd.column + 8'hFF;
    assign hi_step   = (step[0] == 1'b0);

    // backlight level after this command
    always_comb begin
        bl_next = backlight_cur;
        if (cmd.operation == OP_BACKLIGHT) begin
            if (cmd.switch_mode == MODE_TOGGLE) begin
                bl_next = ~backlight_cur;
            end else begin
                bl_next = cmd.switch_mode[0];
            end
        end
    end

    // one strobe of the current command at the current step
    always_comb begin
        addr = 8'h00;
        res = '0;
        res.backlight  = bl_next;
        res.strobe_res = 1'b1;
        unique case (cmd.operation) inside
            OP_DATA: begin
                res.nibble      = hi_step ? cmd.byte_value[7:4] : cmd.byte_value[3:0];
                res.reg_select  = 1'b1;
                res.pre_wait_us = PRE_DATA_US;
                res.pulse_us    = PULSE_STD_US;
                res.post_wait_us = hi_step ? 11'd0 : POST_STD_US;
                res.last        = ~hi_step;
            end
            OP_GOTO: begin
                addr         = goto_addr;
                res.nibble   = hi_step ? addr[7:4] : addr[3:0];
                res.pulse_us = PULSE_GOTO_US;
                res.last     = ~hi_step;
            end
            OP_LINE_START: begin
                addr         = line_base(cmd.line);
                res.nibble   = hi_step ? addr[7:4] : addr[3:0];
                res.pulse_us = PULSE_HOME_US;
                res.last     = ~hi_step;
            end
            OP_CLEAR: begin
                res.nibble   = hi_step ? 4'h0 : 4'h1;
                res.pulse_us = hi_step ? PULSE_STD_US : PULSE_LONG_US;
                res.last     = ~hi_step;
            end
            OP_INIT: begin
                res.nibble       = init_nibble(step);
                res.pre_wait_us  = (step == 4'd0) ? PRE_INIT_US : 16'd0;
                res.pulse_us     = (step == INIT_LONG_STEP) ? PULSE_LONG_US : PULSE_STD_US;
                res.post_wait_us = (step == INIT_LAST_STEP) ? POST_LONG_US : 11'd0;
                res.last         = (step == INIT_LAST_STEP);
            end
            OP_DISPLAY: begin
                res.nibble       = cmd.switch_mode[0] ? DISP_ON_NIB : DISP_OFF_NIB;
                res.pulse_us     = PULSE_STD_US;
                res.post_wait_us = POST_STD_US;
                res.last         = 1'b1;
            end
            OP_BACKLIGHT, OP_UNUSED: begin
                res.strobe_res = 1'b0;
                res.last       = 1'b1;
            end
            default: begin
                res.strobe_res = 1'b0;
                res.last       = 1'b1;
            end
        endcase
    end

endmodule

@@ hdl/char_lcd_4bit_write_sequencer_core.sv @@
// channel | dir | tdata (low bit up)                                   | tuser        | tlast
// s_      | in  | byte_value 8, line 3, column 8, switch_mode 2 (24b)   | operation 3  | -
// m_      | out | nibble 4, reg_select 1, pre_wait_us 16, pulse_us 11,  | strobe_res 1 | last
//         |     | post_wait_us 11, backlight 1 (48b)                   |              |
//
// a command gives N result words (N = 1, 2 or 9): one per strobe, or one non-strobe word
// a step counter walks the registered command, one result per cycle while not stalled
// the next command is taken in the cycle its predecessor's last word is issued,
// so one-word commands flow at one per cycle when not stalled
// aresetn (synchronous) clears the backlight level and empties both stages
// m_tready low holds the output register, and the command stage waits behind it
module char_lcd_4bit_write_sequencer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // byte_value, line, column, switch_mode, pad
    input  logic [2:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // nibble, reg_select, pre_wait_us, pulse_us,
                                   // post_wait_us, backlight, pad
    output logic [0:0]  m_tuser,   // strobe_res
    output logic        m_tlast
);
    import lcd4_pkg::*;

    cmd_t       cmd_reg;
    cmd_t       cmd_in;
    logic       cmd_valid_reg;
    logic [3:0] step_reg;
    logic       bl_reg;
    res_t       gen_res;
    res_t       out_reg;
    logic       out_valid_reg;
    logic       advance;
    logic       s_accept;

    // unpack the input word
    assign cmd_in.operation   = op_t'(s_tuser);
    assign cmd_in.byte_value  = s_tdata[7:0];
    assign cmd_in.line        = s_tdata[10:8];
    assign cmd_in.column      = s_tdata[18:11];
    assign cmd_in.switch_mode = s_tdata[20:19];

    lcd4_strobe_gen u_gen (
        .cmd           (cmd_reg),
        .step          (step_reg),
        .backlight_cur (bl_reg),
        .res           (gen_res)
    );

    // handshake between the command stage and the output register
    assign advance  = cmd_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !cmd_valid_reg || (advance && gen_res.last);
    assign s_accept = s_tvalid && s_tready;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
            step_reg      <= 4'd0;
            bl_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                bl_reg        <= gen_res.backlight;
                step_reg      <= gen_res.last ? 4'd0 : step_reg + 4'd1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (s_accept) begin
                cmd_valid_reg <= 1'b1;
            end else if (advance && gen_res.last) begin
                cmd_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg <= cmd_in;
        end
        if (advance) begin
            out_reg <= gen_res;
        end
    end

    // pack the output word
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.backlight, out_reg.post_wait_us, out_reg.pulse_us,
                       out_reg.pre_wait_us, out_reg.reg_select, out_reg.nibble};
    assign m_tuser  = out_reg.strobe_res;
    assign m_tlast  = out_reg.last;

endmodule

@@ hdl/lcd4_checker.sv @@
module lcd4_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result word changed while stalled");

    // reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a word without a strobe ends its run and carries no bus action
    a_nostrobe: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata[42:0] == 43'd0))
        else $error("non-strobe word with bus fields set");

    // data writes use the standard enable pulse
    a_data_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> m_tuser[0] && (m_tdata[31:21] == 11'd40))
        else $error("data strobe with wrong pulse width");

    // an empty output with no command pending leaves the input open
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !m_tvalid && !$past(s_tvalid) && !$past(m_tvalid) |-> s_tready)
        else $error("input stalled while the block is empty");

endmodule

bind char_lcd_4bit_write_sequencer_core lcd4_checker u_lcd4_checker (.*);
